@@ rtl/recent_id_duplicate_filter_defines.svh @@
// Assertion macros shared by the recent ID duplicate filter RTL.
// Expects clk_i, and rst_ni for RIDF_ASSERT, in the scope of every use.
`ifndef RECENT_ID_DUPLICATE_FILTER_DEFINES_SVH
`define RECENT_ID_DUPLICATE_FILTER_DEFINES_SVH

// checked while out of reset
`define RIDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define RIDF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/rifd_pkg.sv @@
// Shared types and constants of the recent ID duplicate filter.
// No dependencies.
package rifd_pkg;

  localparam int unsigned EVENT_ID_W = 32;
  localparam int unsigned WLEN_W     = 9;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd256;

  // fan-in of one level of the registered match reduction
  localparam int unsigned RED_GROUP = 16;

  typedef struct packed {
    logic shift;  // take neighbor's entry
    logic flush;  // drop all entries
  } rifd_cell_ctl_t;

endpackage

@@ rtl/rifd_cell.sv @@
// One window cell: holds one identifier, shifts it to the next cell on insert,
// and registers whether it matches the current query. Uses rifd_pkg.
module rifd_cell #(
  parameter int unsigned ID_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rifd_pkg::rifd_cell_ctl_t ctl_i,
  input  logic                  in_win_i,
  input  logic [ID_BITS-1:0]    query_i,
  input  logic [ID_BITS-1:0]    prev_id_i,
  input  logic                  prev_valid_i,
  output logic [ID_BITS-1:0]    id_o,
  output logic                  valid_o,
  output logic                  hit_o
);
  import rifd_pkg::*;

  logic [ID_BITS-1:0] id_q;
  logic               valid_q;
  logic               hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.flush) begin
      valid_q <= 1'b0;
    end else if (ctl_i.shift) begin
      valid_q <= prev_valid_i && in_win_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      id_q <= prev_id_i;
    end
    hit_q <= valid_q && (id_q == query_i);
  end

  assign id_o    = id_q;
  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule

@@ rtl/rifd_or_tree.sv @@
// Two registered OR levels that fold the per-cell hit bits into one hit flag.
// Uses rifd_pkg for the group fan-in.
module rifd_or_tree #(
  parameter int unsigned N = 256
) (
  input  logic         clk_i,
  input  logic [N-1:0] hits_i,
  output logic         hit_o
);
  import rifd_pkg::*;

  localparam int unsigned G1  = (N + RED_GROUP - 1) / RED_GROUP;
  localparam int unsigned G2  = (G1 + RED_GROUP - 1) / RED_GROUP;
  localparam int unsigned PW1 = G1 * RED_GROUP;
  localparam int unsigned PW2 = G2 * RED_GROUP;

  logic [PW1-1:0] pad1;
  logic [PW2-1:0] pad2;
  logic [G1-1:0]  l1_q;
  logic [G2-1:0]  l2_q;

  assign pad1 = PW1'(hits_i);
  assign pad2 = PW2'(l1_q);

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < G1; g++) begin
      l1_q[g] <= |pad1[g*RED_GROUP +: RED_GROUP];
    end
    for (int g = 0; g < G2; g++) begin
      l2_q[g] <= |pad2[g*RED_GROUP +: RED_GROUP];
    end
  end

  assign hit_o = |l2_q;

endmodule

@@ rtl/recent_id_duplicate_filter.sv @@
// Top level of the recent ID duplicate filter: cell row, match reduction, control.
// Depends on rifd_pkg, rifd_cell, rifd_or_tree and the defines header.
//
// Drops event IDs already seen among the most recent distinct nonzero IDs. The
// window is a row of cells, newest in cell 0; a stored ID shifts one cell on each
// insert and falls out past the effective window length (oldest first). ID zero
// always passes and is never stored. One beat is processed at a time: an ID is
// accepted, compared in every cell, the hit bits are reduced through two
// registered OR levels, and the result is loaded into the output register in
// ST_COMMIT, which waits while an earlier result is held there by out_stall_i;
// the next ID is taken the cycle after that load. A result waiting in the output
// register does not block the next ID. Writing window_length empties the window.
module recent_id_duplicate_filter #(
  parameter int unsigned WINDOW_DEPTH = 256,
  parameter int unsigned ID_BITS      = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rifd_pkg::WLEN_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rifd_pkg::EVENT_ID_W-1:0] event_id_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            forward_o,
  output logic                            recorded_o,
  output logic                            evicted_o
);
  import rifd_pkg::*;

  `include "recent_id_duplicate_filter_defines.svh"

  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned LW = (CW > WLEN_W) ? CW : WLEN_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MATCH  = 3'd1;
  localparam logic [2:0] ST_RED1   = 3'd2;
  localparam logic [2:0] ST_RED2   = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [ID_BITS-1:0] query_q;
  logic [WLEN_W-1:0]  wlen_q;
  logic [CW-1:0]      fill_q, fill_d;
  logic               out_valid_q, out_valid_d;
  logic               forward_q, recorded_q, evicted_q;

  logic [LW-1:0]      wl_ext;
  logic [CW-1:0]      len_eff;
  logic               in_fire, cfg_fire, commit_fire;
  logic               hit, is_zero, store, full;
  rifd_cell_ctl_t     ctl;

  logic [ID_BITS-1:0]      cell_id [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] cell_valid;
  logic [WINDOW_DEPTH-1:0] cell_hit;
  logic [WINDOW_DEPTH-1:0] in_win;

  // effective length: 0 acts as 1, clipped to the depth
  always_comb begin
    wl_ext = LW'(wlen_q);
    if (wl_ext == '0) begin
      len_eff = CW'(1);
    end else if (wl_ext > LW'(WINDOW_DEPTH)) begin
      len_eff = CW'(WINDOW_DEPTH);
    end else begin
      len_eff = CW'(wl_ext);
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign commit_fire = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall_i);

  assign is_zero = (query_q == '0);
  assign store   = !is_zero && !hit;
  assign full    = (fill_q >= len_eff);

  assign ctl.shift = commit_fire && store;
  assign ctl.flush = cfg_fire;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_MATCH;
      ST_MATCH:  state_d = ST_RED1;
      ST_RED1:   state_d = ST_RED2;
      ST_RED2:   state_d = ST_COMMIT;
      ST_COMMIT: if (commit_fire) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    fill_d = fill_q;
    if (cfg_fire) begin
      fill_d = '0;
    end else if (ctl.shift && !full) begin
      fill_d = fill_q + CW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      wlen_q      <= WLEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_fire) begin
        wlen_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      query_q <= ID_BITS'(event_id_i);
    end
    if (commit_fire) begin
      forward_q  <= is_zero || !hit;
      recorded_q <= store;
      evicted_q  <= store && full;
    end
  end

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    assign in_win[i] = (CW'(i) < len_eff);
    if (i == 0) begin : g_head
      rifd_cell #(.ID_BITS(ID_BITS)) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctl_i       (ctl),
        .in_win_i    (in_win[i]),
        .query_i     (query_q),
        .prev_id_i   (query_q),
        .prev_valid_i(1'b1),
        .id_o        (cell_id[i]),
        .valid_o     (cell_valid[i]),
        .hit_o       (cell_hit[i])
      );
    end else begin : g_body
      rifd_cell #(.ID_BITS(ID_BITS)) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctl_i       (ctl),
        .in_win_i    (in_win[i]),
        .query_i     (query_q),
        .prev_id_i   (cell_id[i-1]),
        .prev_valid_i(cell_valid[i-1]),
        .id_o        (cell_id[i]),
        .valid_o     (cell_valid[i]),
        .hit_o       (cell_hit[i])
      );
    end
  end

  rifd_or_tree #(.N(WINDOW_DEPTH)) u_or_tree (
    .clk_i (clk_i),
    .hits_i(cell_hit),
    .hit_o (hit)
  );

  assign out_valid_o = out_valid_q;
  assign forward_o   = forward_q;
  assign recorded_o  = recorded_q;
  assign evicted_o   = evicted_q;

  `RIDF_ASSERT(a_fill_bound, fill_q <= len_eff, "fill count exceeds window length")
  `RIDF_ASSERT(a_evict_needs_store, out_valid_o && evicted_o |-> recorded_o && forward_o,
               "eviction without a stored beat")
  `RIDF_ASSERT(a_drop_clean, out_valid_o && !forward_o |-> !recorded_o && !evicted_o,
               "dropped beat marked as stored")
  `RIDF_ASSERT(a_store_fills, ctl.shift |=> fill_q != '0, "store left window empty")
  `RIDF_ASSERT_ALWAYS(a_no_cfg_busy, cfg_ready_o |-> !in_stall_o,
                      "config taken while a beat is in flight")

endmodule
